@@ sv/tlv_pkg.sv @@
package tlv_pkg;

	// Frame size limit; bytes past this position are ignored.
	localparam int FRAME_BYTES = 512;
	// Byte position counter holds 0 .. FRAME_BYTES.
	localparam int POS_W = $clog2(FRAME_BYTES + 1);
	// Container end is a position plus a one-byte length.
	localparam int END_W = $clog2(FRAME_BYTES + 256 + 1);

	// Tag codes of the directory structure.
	localparam logic [7:0] TAG_A5 = 8'hA5;
	localparam logic [7:0] TAG_BF = 8'hBF;
	localparam logic [7:0] TAG_0C = 8'h0C;
	localparam logic [7:0] TAG_61 = 8'h61;
	localparam logic [7:0] TAG_4F = 8'h4F;
	localparam logic [7:0] TAG_50 = 8'h50;
	localparam logic [7:0] TAG_9F = 8'h9F;
	localparam logic [7:0] TAG_0A = 8'h0A;
	localparam logic [7:0] TAG_NONE = 8'h00;

	// Parser phase within one element.
	typedef enum logic [2:0] {
		PH_TAG  = 3'd0,
		PH_TAG2 = 3'd1,
		PH_LEN  = 3'd2,
		PH_AID  = 3'd3,
		PH_SKIP = 3'd4
	} phase_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] aid_byte;
		logic       byte_valid;
		logic       aid_last;
		logic       frame_done;
		logic [7:0] aid_total;
		logic       format_error;
	} res_t;

endpackage

@@ sv/tlv_parser.sv @@
module tlv_parser import tlv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] b,
	input  logic       last,
	output logic       produce,
	output res_t       res
);

	typedef struct packed {
		logic [1:0] lvl;
		logic       err;
	} close_t;

	logic [POS_W-1:0] pos_q;
	logic [1:0]       level_q;
	phase_t           phase_q;
	logic [END_W-1:0] end_q [3];
	logic [7:0]       rem_q;
	logic [7:0]       held_q;
	logic [7:0]       count_q;
	logic             err_q;

	logic [1:0]       level_n;
	phase_t           phase_n;
	logic [END_W-1:0] end_n [3];
	logic [7:0]       rem_n;
	logic [7:0]       held_n;
	logic [7:0]       count_n;
	logic             err_n;

	logic             active;
	logic [END_W-1:0] qe;
	logic [END_W-1:0] open_end;
	logic             aid_valid;
	logic             aid_end;
	logic             do_done;
	close_t           closed;

	// Closes every container that ends at position q, innermost first.
	// An element running past a BF0C or 61 container flags an error.
	function automatic close_t close_levels(input logic [END_W-1:0] q,
			input logic [1:0] lvl_in, input logic [END_W-1:0] ends [3]);
		close_t r;
		logic   stop;
		r.lvl = lvl_in;
		r.err = 1'b0;
		stop  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!stop && r.lvl != 2'd0 && q >= ends[2'(r.lvl - 2'd1)]) begin
				if (q > ends[2'(r.lvl - 2'd1)] && r.lvl >= 2'd2) begin
					r.err = 1'b1;
					stop  = 1'b1;
				end else begin
					r.lvl = r.lvl - 2'd1;
				end
			end else begin
				stop = 1'b1;
			end
		end
		return r;
	endfunction

	assign active   = !err_q && (pos_q < POS_W'(FRAME_BYTES));
	assign qe       = END_W'(pos_q) + END_W'(1);
	assign open_end = qe + END_W'(b);

	// Result flags for this byte.
	always_comb begin
		aid_valid = active && (phase_q == PH_AID);
		aid_end   = active && (((phase_q == PH_AID) && (rem_q == 8'd1)) ||
			((phase_q == PH_LEN) && (held_q == TAG_4F) && (b == 8'd0)));
	end

	// Next parser state for this byte.
	always_comb begin
		level_n = level_q;
		phase_n = phase_q;
		end_n   = end_q;
		rem_n   = rem_q;
		held_n  = held_q;
		err_n   = err_q;
		count_n = count_q;
		do_done = 1'b0;
		closed  = '0;
		if (active) begin
			unique case (phase_q)
				PH_TAG: begin
					held_n  = TAG_NONE;
					phase_n = PH_LEN;
					if (level_q == 2'd0 && b == TAG_A5) begin
						held_n = TAG_A5;
					end else if (level_q == 2'd1 && b == TAG_BF) begin
						held_n  = TAG_BF;
						phase_n = PH_TAG2;
					end else if (level_q == 2'd2 && b == TAG_61) begin
						held_n = TAG_61;
					end else if (level_q == 2'd3 && b == TAG_4F) begin
						held_n = TAG_4F;
					end else if (level_q == 2'd3 && b == TAG_9F) begin
						held_n  = TAG_9F;
						phase_n = PH_TAG2;
					end
				end
				PH_TAG2: begin
					if ((held_q == TAG_BF && b == TAG_0C) ||
							(held_q == TAG_9F && b == TAG_0A)) begin
						held_n  = (held_q == TAG_BF) ? TAG_0C : TAG_NONE;
						phase_n = PH_LEN;
					end else begin
						held_n = TAG_NONE;
						rem_n  = b;
						if (b == 8'd0) begin
							do_done = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_LEN: begin
					if (held_q == TAG_A5) begin
						end_n[0] = open_end;
						level_n  = 2'd1;
						do_done  = 1'b1;
					end else if (held_q == TAG_0C) begin
						end_n[1] = open_end;
						level_n  = 2'd2;
						do_done  = 1'b1;
					end else if (held_q == TAG_61) begin
						end_n[2] = open_end;
						level_n  = 2'd3;
						do_done  = 1'b1;
					end else if (held_q == TAG_4F) begin
						if (b == 8'd0) begin
							do_done = 1'b1;
						end else begin
							rem_n   = b;
							phase_n = PH_AID;
						end
					end else begin
						// Skipped element, including 50 and 9F0A.
						rem_n = b;
						if (b == 8'd0) begin
							do_done = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_AID, PH_SKIP: begin
					rem_n = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						do_done = 1'b1;
					end
				end
				default: begin
					phase_n = PH_TAG;
				end
			endcase
			if (aid_end && count_q != 8'hFF) begin
				count_n = count_q + 8'd1;
			end
			if (do_done) begin
				closed  = close_levels(qe, level_n, end_n);
				phase_n = PH_TAG;
				level_n = closed.lvl;
				err_n   = err_q | closed.err;
			end
		end
	end

	assign produce          = aid_valid || aid_end || last;
	assign res.aid_byte     = aid_valid ? b : 8'd0;
	assign res.byte_valid   = aid_valid;
	assign res.aid_last     = aid_end;
	assign res.frame_done   = last;
	assign res.aid_total    = count_n;
	assign res.format_error = err_n;

	// State registers; the frame's last byte returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			level_q <= 2'd0;
			phase_q <= PH_TAG;
			end_q   <= '{default: '0};
			rem_q   <= 8'd0;
			held_q  <= TAG_NONE;
			count_q <= 8'd0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				pos_q   <= '0;
				level_q <= 2'd0;
				phase_q <= PH_TAG;
				end_q   <= '{default: '0};
				rem_q   <= 8'd0;
				held_q  <= TAG_NONE;
				count_q <= 8'd0;
				err_q   <= 1'b0;
			end else begin
				if (pos_q < POS_W'(FRAME_BYTES)) begin
					pos_q <= pos_q + POS_W'(1);
				end
				level_q <= level_n;
				phase_q <= phase_n;
				end_q   <= end_n;
				rem_q   <= rem_n;
				held_q  <= held_n;
				count_q <= count_n;
				err_q   <= err_n;
			end
		end
	end

	// The end of a frame clears the frame state.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> pos_q == '0 && level_q == 2'd0 && count_q == 8'd0 && !err_q)
		else $error("frame state not cleared after last byte");

	// An error holds until the frame ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(step && last) |=> err_q)
		else $error("format error dropped inside a frame");

	// After an error the parser state is frozen.
	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last && err_q |=> $stable(level_q) && phase_q == $past(phase_q))
		else $error("parser moved after a format error");

	// Identifier bytes are only read inside a 61 container.
	a_aid_level: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AID |-> level_q == 2'd3)
		else $error("identifier phase outside level three");

endmodule

@@ sv/tlv_result_reg.sv @@
module tlv_result_reg import tlv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_stall,
	output logic free,
	output logic out_valid,
	output res_t res_q
);

	logic res_valid_q;

	// The slot can take a new result when empty or being drained.
	assign free      = !res_valid_q || !out_stall;
	assign out_valid = res_valid_q;

	// Valid flag of the result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Payload of the result slot.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

@@ sv/tlv_aid_extractor.sv @@
// Data path: an accepted byte waits in the input stage register, the parser
// stage works on it there, and its result is written into the result register,
// from which the result transaction completes.
// Throughput: one byte per cycle unless a byte with a result meets a stalled, full
// result register; the rate is set by the single parser stage that updates the element state once per byte.
// Reset: arst_n clears the parser state and both stage valid flags.
module tlv_aid_extractor import tlv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] aid_byte,
	output logic       byte_valid,
	output logic       aid_last,
	output logic       frame_done,
	output logic [7:0] aid_total,
	output logic       format_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       produce;
	logic       free;
	logic       advance;
	logic       load;
	res_t       res_new;
	res_t       res_out;

	// A byte leaves the input stage when its result has room or it has none.
	assign advance  = valid_s1 && (!produce || free);
	assign load     = advance && produce;
	assign in_stall = valid_s1 && !advance;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= frame_last;
		end
	end

	tlv_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.b       (byte_s1),
		.last    (last_s1),
		.produce (produce),
		.res     (res_new)
	);

	tlv_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_in    (res_new),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.res_q     (res_out)
	);

	assign aid_byte     = res_out.aid_byte;
	assign byte_valid   = res_out.byte_valid;
	assign aid_last     = res_out.aid_last;
	assign frame_done   = res_out.frame_done;
	assign aid_total    = res_out.aid_total;
	assign format_error = res_out.format_error;

	// A result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid || !out_stall)
		else $error("result overwritten while stalled");

	// A stalled input stage holds a byte whose result has no room.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && produce && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// A byte that advances with a result shows up at the output next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded result not presented");

endmodule

@@ bench/tb_tlv_aid_extractor.sv @@
`timescale 1ns / 1ps

module tb_tlv_aid_extractor;
	import tlv_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 12;

	typedef logic [7:0] byte_q_t [$];

	// One row of the directed table; fixed rows carry their own result.
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         fixed;
		res_t       want;
	} dir_row_t;

	localparam res_t NO_RES = '0;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       frame_last   = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] aid_byte;
	logic       byte_valid;
	logic       aid_last;
	logic       frame_done;
	logic [7:0] aid_total;
	logic       format_error;

	// Directory parser state as predicted.
	int unsigned dir_pos;
	logic [1:0]  dir_level;
	phase_t      dir_phase;
	int unsigned dir_end [3];
	logic [7:0]  dir_left;
	logic [7:0]  dir_tag;
	logic [7:0]  dir_aids;
	logic        dir_err;

	res_t pending_results [$];
	int   n_sent       = 0;
	int   n_fail       = 0;
	int   src_idle_pct = 19;
	int   snk_idle_pct = 87;
	bit   hold_req     = 1'b0;

	// Reset row, a well-formed directory, and a frame whose identifier overruns its entry.
	dir_row_t dir_rows [27] = '{
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{8'hA5, 1'b0, 1'b0, NO_RES},
		'{8'h0D, 1'b0, 1'b0, NO_RES},
		'{8'hBF, 1'b0, 1'b0, NO_RES},
		'{8'h0C, 1'b0, 1'b0, NO_RES},
		'{8'h0A, 1'b0, 1'b0, NO_RES},
		'{8'h61, 1'b0, 1'b0, NO_RES},
		'{8'h08, 1'b0, 1'b0, NO_RES},
		'{8'h4F, 1'b0, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'h4F, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'h9F, 1'b0, 1'b0, NO_RES},
		'{8'h0A, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'hA5, 1'b0, 1'b0, NO_RES},
		'{8'h06, 1'b0, 1'b0, NO_RES},
		'{8'hBF, 1'b0, 1'b0, NO_RES},
		'{8'h0C, 1'b0, 1'b0, NO_RES},
		'{8'h03, 1'b0, 1'b0, NO_RES},
		'{8'h61, 1'b0, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b0, NO_RES},
		'{8'h4F, 1'b0, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b0, NO_RES},
		'{8'hAB, 1'b0, 1'b0, NO_RES},
		'{8'hCD, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 8'h01, 1'b1}}
	};

	tlv_aid_extractor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.frame_last   (frame_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.aid_byte     (aid_byte),
		.byte_valid   (byte_valid),
		.aid_last     (aid_last),
		.frame_done   (frame_done),
		.aid_total    (aid_total),
		.format_error (format_error)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Return the parser to the start of a frame.
	function automatic void clear_parser();
		dir_pos   = 0;
		dir_level = 2'd0;
		dir_phase = PH_TAG;
		dir_end   = '{0, 0, 0};
		dir_left  = 8'h00;
		dir_tag   = TAG_NONE;
		dir_aids  = 8'h00;
		dir_err   = 1'b0;
	endfunction

	// An element ended at position q; close every container that ends there too.
	function automatic void close_elements(int unsigned q);
		dir_phase = PH_TAG;
		while (dir_level != 2'd0 && q >= dir_end[dir_level - 2'd1]) begin
			if (q > dir_end[dir_level - 2'd1] && dir_level >= 2'd2) begin
				dir_err = 1'b1;
				return;
			end
			dir_level = dir_level - 2'd1;
		end
	endfunction

	function automatic void open_level(logic [1:0] lvl, int unsigned q, logic [7:0] n);
		dir_end[lvl - 2'd1] = q + 32'(n);
		dir_level = lvl;
		close_elements(q);
	endfunction

	function automatic void start_skip(logic [7:0] n, int unsigned q);
		dir_left = n;
		if (n == 8'h00) close_elements(q);
		else dir_phase = PH_SKIP;
	endfunction

	function automatic void count_aid();
		if (dir_aids != 8'hFF) dir_aids = dir_aids + 8'd1;
	endfunction

	// Advance the parser by one byte; returns 1 when the byte yields a result transaction.
	function automatic bit parse_dir_byte(input logic [7:0] b, input logic last, output res_t r);
		int unsigned q;
		bit          got_byte;
		bit          got_end;
		got_byte = 1'b0;
		got_end  = 1'b0;
		r        = '0;
		if (!dir_err && dir_pos < FRAME_BYTES) begin
			q = dir_pos + 1;
			case (dir_phase)
				PH_TAG: begin
					dir_tag   = TAG_NONE;
					dir_phase = PH_LEN;
					if (dir_level == 2'd0 && b == TAG_A5) begin
						dir_tag = TAG_A5;
					end else if (dir_level == 2'd1 && b == TAG_BF) begin
						dir_tag   = TAG_BF;
						dir_phase = PH_TAG2;
					end else if (dir_level == 2'd2 && b == TAG_61) begin
						dir_tag = TAG_61;
					end else if (dir_level == 2'd3 && b == TAG_4F) begin
						dir_tag = TAG_4F;
					end else if (dir_level == 2'd3 && b == TAG_9F) begin
						dir_tag   = TAG_9F;
						dir_phase = PH_TAG2;
					end
				end
				PH_TAG2: begin
					if ((dir_tag == TAG_BF && b == TAG_0C) ||
							(dir_tag == TAG_9F && b == TAG_0A)) begin
						dir_tag   = (dir_tag == TAG_BF) ? TAG_0C : TAG_NONE;
						dir_phase = PH_LEN;
					end else begin
						// The second byte is really the length of a skipped element.
						dir_tag = TAG_NONE;
						start_skip(b, q);
					end
				end
				PH_LEN: begin
					if (dir_tag == TAG_A5) begin
						open_level(2'd1, q, b);
					end else if (dir_tag == TAG_0C) begin
						open_level(2'd2, q, b);
					end else if (dir_tag == TAG_61) begin
						open_level(2'd3, q, b);
					end else if (dir_tag == TAG_4F) begin
						if (b == 8'h00) begin
							got_end = 1'b1;
							count_aid();
							close_elements(q);
						end else begin
							dir_left  = b;
							dir_phase = PH_AID;
						end
					end else begin
						start_skip(b, q);
					end
				end
				PH_AID: begin
					got_byte = 1'b1;
					dir_left = dir_left - 8'd1;
					if (dir_left == 8'h00) begin
						got_end = 1'b1;
						count_aid();
						close_elements(q);
					end
				end
				PH_SKIP: begin
					dir_left = dir_left - 8'd1;
					if (dir_left == 8'h00) close_elements(q);
				end
				default: begin
					dir_phase = PH_TAG;
				end
			endcase
		end
		if (dir_pos < FRAME_BYTES) dir_pos = dir_pos + 1;

		if (!(got_byte || got_end || last)) return 1'b0;
		r.aid_byte     = got_byte ? b : 8'h00;
		r.byte_valid   = got_byte;
		r.aid_last     = got_end;
		r.frame_done   = last;
		r.aid_total    = dir_aids;
		r.format_error = dir_err;
		if (last) clear_parser();
		return 1'b1;
	endfunction

	// Frame construction.
	function automatic void add_byte(ref byte_q_t dst, input logic [7:0] v);
		dst.insert(dst.size(), v);
	endfunction

	function automatic byte_q_t rand_bytes(int unsigned n);
		byte_q_t r;
		repeat (n) add_byte(r, 8'($urandom));
		return r;
	endfunction

	function automatic void append_bytes(ref byte_q_t dst, input byte_q_t src);
		foreach (src[i]) add_byte(dst, src[i]);
	endfunction

	function automatic logic [7:0] other_tag(logic [7:0] a, logic [7:0] b);
		logic [7:0] t;
		do t = 8'($urandom); while (t == a || t == b);
		return t;
	endfunction

	// Tag bytes, a length byte, then the body; now and then the length is off by a few.
	function automatic byte_q_t tlv_wrap(byte_q_t head, byte_q_t body);
		byte_q_t r;
		int      n;
		r = head;
		n = body.size();
		if ($urandom_range(11) == 0) n = n + int'($urandom_range(6)) - 3;
		if (n < 0) n = 0;
		if (n > 255) n = 255;
		add_byte(r, 8'(n));
		append_bytes(r, body);
		return r;
	endfunction

	// One element inside an application entry.
	function automatic byte_q_t make_l3();
		byte_q_t     h;
		int unsigned k;
		int unsigned n;
		k = $urandom_range(99);
		if (k < 45) begin
			add_byte(h, TAG_4F);
			if ($urandom_range(9) == 0) n = 0;
			else if ($urandom_range(7) == 0) n = $urandom_range(16, 1);
			else n = $urandom_range(8, 1);
		end else if (k < 55) begin
			add_byte(h, TAG_50);
			n = $urandom_range(8);
		end else if (k < 65) begin
			add_byte(h, TAG_9F);
			add_byte(h, TAG_0A);
			n = $urandom_range(4);
		end else if (k < 75) begin
			// 9F with another second byte, which then acts as the length.
			add_byte(h, TAG_9F);
			n = $urandom_range(6);
		end else begin
			add_byte(h, other_tag(TAG_4F, TAG_9F));
			n = $urandom_range(5);
		end
		return tlv_wrap(h, rand_bytes(n));
	endfunction

	// An application entry, possibly empty, or a stray element beside it.
	function automatic byte_q_t make_l2();
		byte_q_t h;
		byte_q_t body;
		if ($urandom_range(4) != 0) begin
			add_byte(h, TAG_61);
			repeat ($urandom_range(4)) append_bytes(body, make_l3());
			return tlv_wrap(h, body);
		end
		add_byte(h, other_tag(TAG_61, TAG_61));
		return tlv_wrap(h, rand_bytes($urandom_range(4)));
	endfunction

	// The BF0C directory, a BF with a foreign second byte, or another element.
	function automatic byte_q_t make_l1();
		byte_q_t     h;
		byte_q_t     body;
		int unsigned k;
		k = $urandom_range(4);
		if (k < 3) begin
			add_byte(h, TAG_BF);
			add_byte(h, TAG_0C);
			repeat ($urandom_range(3, 1)) append_bytes(body, make_l2());
			return tlv_wrap(h, body);
		end
		add_byte(h, (k == 3) ? TAG_BF : other_tag(TAG_BF, TAG_BF));
		return tlv_wrap(h, rand_bytes($urandom_range((k == 3) ? 6 : 4)));
	endfunction

	// A whole frame: mostly well-formed, some noise, truncated or oversize ones.
	function automatic byte_q_t make_frame();
		byte_q_t     f;
		byte_q_t     h;
		byte_q_t     body;
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 10) return rand_bytes($urandom_range(30, 1));
		if ($urandom_range(4) == 0) begin
			add_byte(h, other_tag(TAG_A5, TAG_A5));
			append_bytes(f, tlv_wrap(h, rand_bytes($urandom_range(4))));
		end
		repeat ($urandom_range(2, 1)) begin
			body.delete();
			h.delete();
			add_byte(h, TAG_A5);
			repeat ($urandom_range(2, 1)) append_bytes(body, make_l1());
			append_bytes(f, tlv_wrap(h, body));
		end
		if (kind < 20) begin
			repeat ($urandom_range(f.size() - 1)) void'(f.pop_back());
		end else if (kind < 23) begin
			while (f.size() < FRAME_BYTES + 24) add_byte(f, 8'($urandom));
		end
		return f;
	endfunction

	// Offer one byte, wait for its transaction, then record what it should produce.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit fixed,
		input res_t want);
		res_t pred;
		bit   has;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		frame_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		has = parse_dir_byte(b, last, pred);
		if (fixed) pending_results.insert(pending_results.size(), want);
		else if (has) pending_results.insert(pending_results.size(), pred);
	endtask

	// Stimulus: reset, directed table, then random frames in three idling phases.
	initial begin : stimulus
		byte_q_t frame;
		int      stage;
		stage = 0;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fixed,
				dir_rows[i].want);
		end

		while (n_sent < ITEM_TARGET) begin
			if (stage == 0 && n_sent >= ITEM_TARGET / 3) begin
				// Let the block drain completely before swapping the idle rates.
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
				src_idle_pct = 87;
				snk_idle_pct = 19;
				stage = 1;
			end else if (stage == 1 && n_sent >= 2 * ITEM_TARGET / 3) begin
				// No idling from here on; the receiver first holds off for a long stretch.
				src_idle_pct = 0;
				snk_idle_pct = 0;
				hold_req = 1'b1;
				stage = 2;
			end
			frame = make_frame();
			foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, 1'b0, NO_RES);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0) begin
			$display("tlv_aid_extractor: match");
		end else begin
			$display("tlv_aid_extractor: mismatch");
		end
		$finish;
	end

	// Result side: check each transaction against the oldest expectation, then pick the stall.
	initial begin : result_check
		res_t got;
		res_t want;
		int   hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{aid_byte, byte_valid, aid_last, frame_done, aid_total, format_error};
				if (pending_results.size() == 0) begin
					$error("unexpected result transaction: aid_byte %0h aid_total %0d",
						got.aid_byte, got.aid_total);
					n_fail++;
				end else begin
					want = pending_results.pop_front();
					if (got.aid_byte !== want.aid_byte) begin
						$error("aid_byte: expected %0h, got %0h", want.aid_byte, got.aid_byte);
						n_fail++;
					end
					if (got.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
						n_fail++;
					end
					if (got.aid_last !== want.aid_last) begin
						$error("aid_last: expected %0b, got %0b", want.aid_last, got.aid_last);
						n_fail++;
					end
					if (got.frame_done !== want.frame_done) begin
						$error("frame_done: expected %0b, got %0b", want.frame_done,
							got.frame_done);
						n_fail++;
					end
					if (got.aid_total !== want.aid_total) begin
						$error("aid_total: expected %0d, got %0d", want.aid_total, got.aid_total);
						n_fail++;
					end
					if (got.format_error !== want.format_error) begin
						$error("format_error: expected %0b, got %0b", want.format_error,
							got.format_error);
						n_fail++;
					end
				end
			end

			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < snk_idle_pct);
			end
		end
	end

	// Give up if the run hangs.
	initial begin : watchdog
		#(5_000_000);
		$display("tlv_aid_extractor: mismatch");
		$finish;
	end

endmodule
